// ===== rtl/core/line_framer_slot_pool_assert.svh =====
// Assertion macros used by the port-level checker of the line framer slot pool.
`ifndef LINE_FRAMER_SLOT_POOL_ASSERT_SVH
`define LINE_FRAMER_SLOT_POOL_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define LFSP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define LFSP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lfsp_pkg.sv =====
// Package of the line framer slot pool: payload types, codes and defaults.
package lfsp_pkg;

	localparam int SLOTS_DEF      = 8;
	localparam int LINE_BYTES_DEF = 160;

	localparam logic [1:0] ACT_BYTE = 2'd0;
	localparam logic [1:0] ACT_REL  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;
	localparam logic [1:0] ACT_DISC = 2'd3;

	localparam logic [1:0] KIND_LINE  = 2'd0;
	localparam logic [1:0] KIND_ERROR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
		logic [2:0] slot_sel;
		logic [7:0] byte_offset;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] slot;
		logic [7:0] line_length;
		logic [7:0] read_data;
	} result_t;

	// Commands from the sequencer to the slot pool.
	typedef struct packed {
		logic rel;
		logic take;
		logic start;
		logic step;
	} pool_ctl_t;

	// Status of the current search candidate.
	typedef struct packed {
		logic cand_free;
		logic last;
	} pool_sts_t;

endpackage

// ===== rtl/core/lfsp_slot_pool.sv =====
// Busy map, next pointer and the round-robin search step unit of the slot pool.
module lfsp_slot_pool #(
	parameter int SLOTS = lfsp_pkg::SLOTS_DEF,
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lfsp_pkg::pool_ctl_t ctl,
	input  logic [SW-1:0]       rel_idx,
	output lfsp_pkg::pool_sts_t sts,
	output logic [SW-1:0]       cand
);
	import lfsp_pkg::*;

	logic [SLOTS-1:0] busy_q;
	logic [SW-1:0]    next_q;
	logic [SW-1:0]    cand_q;
	logic [SW-1:0]    cnt_q;
	logic [SW-1:0]    cand_inc;

	// Wrapping increment of the candidate, shared by the search step and the pointer update.
	assign cand_inc = (cand_q == SW'(SLOTS - 1)) ? '0 : cand_q + 1'b1;

	assign sts.cand_free = ~busy_q[cand_q];
	assign sts.last      = (cnt_q == SW'(SLOTS - 1));
	assign cand          = cand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			next_q <= '0;
			cand_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (ctl.rel) begin
				busy_q[rel_idx] <= 1'b0;
			end
			if (ctl.take) begin
				busy_q[cand_q] <= 1'b1;
				next_q         <= cand_inc;
			end
			if (ctl.start) begin
				cand_q <= next_q;
				cnt_q  <= '0;
			end else if (ctl.step) begin
				cand_q <= cand_inc;
				cnt_q  <= cnt_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/line_framer_slot_pool.sv =====
// Top level of the line framer slot pool: sequencer, assembly buffer and line store.
//
//   channel   direction   handshake                     payload
//   item      in          item_valid / item_stall       lfsp_pkg::item_t
//   result    out         result_valid / result_stall   lfsp_pkg::result_t
//
// A plain received byte, a release and a disconnect leave the sequencer idle.
// A read passes through address, memory read, data capture and result load.
// A line end runs a search that probes 1 to SLOTS slots, then the copy path,
// one byte a cycle for the line and its zero terminator, then the result load.
// The busy map is cleared at once by reset; no clearing pass is run.
// A stalled result waits in the output register while the next item is accepted.
module line_framer_slot_pool #(
	parameter int SLOTS      = lfsp_pkg::SLOTS_DEF,
	parameter int LINE_BYTES = lfsp_pkg::LINE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lfsp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output lfsp_pkg::result_t result
);
	import lfsp_pkg::*;

	// Widths of the slot index, the byte count and the line store address.
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(LINE_BYTES);
	localparam int AW = $clog2(SLOTS * LINE_BYTES);

	// The sequencer walks a terminated line through search, copy and report, and a read through memory read and report.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COPY,
		ST_MEMRD,
		ST_MEMWAIT,
		ST_EMIT
	} state_t;

	state_t    state_q;
	logic [CW-1:0] count_q;
	logic      ovf_q;
	logic      prev_cr_q;
	result_t   pend_q;
	result_t   result_q;
	logic      result_valid_q;
	logic      st_wr_s1;

	// Copy and read datapath registers.
	logic [CW-1:0] idx_q;
	logic [AW-1:0] wr_addr_q;
	logic [AW-1:0] rd_addr_q;
	logic [AW-1:0] addr_s1;
	logic          zero_s1;
	logic [7:0]    abuf_rdata_q;
	logic [7:0]    ls_rdata_q;

	logic [7:0] abuf_mem [LINE_BYTES];
	logic [7:0] ls_mem [SLOTS * LINE_BYTES];

	logic      acc;
	logic      is_cr;
	logic      is_lf;
	logic      byte_act;
	logic      end_line;
	logic      keep_byte;
	logic      sel_ok;
	logic      rd_ok;
	logic      emit_go;
	pool_ctl_t pool_ctl;
	pool_sts_t pool_sts;
	logic [SW-1:0] cand;

	// Items are taken only while the sequencer is idle.
	assign item_stall   = (state_q != ST_IDLE);
	assign acc          = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign byte_act  = acc && (item.action == ACT_BYTE);
	assign is_cr     = (item.rx_byte == CHAR_CR);
	assign is_lf     = (item.rx_byte == CHAR_LF);
	// A CR always ends a line; an LF ends one unless it closes a CR-LF pair.
	assign end_line  = byte_act && (is_cr || (is_lf && !prev_cr_q));
	assign keep_byte = byte_act && !is_cr && !is_lf && (count_q < CW'(LINE_BYTES - 1));
	assign sel_ok    = (32'(item.slot_sel) < SLOTS);
	assign rd_ok     = sel_ok && (32'(item.byte_offset) < LINE_BYTES);

	// The pending result moves to the output register once that register is free
	// or is handing its transaction over in this cycle.
	assign emit_go   = (state_q == ST_EMIT) && (!result_valid_q || !result_stall);

	always_comb begin
		pool_ctl.rel   = acc && (item.action == ACT_REL) && sel_ok;
		pool_ctl.start = end_line && !ovf_q && (count_q != '0);
		pool_ctl.take  = (state_q == ST_SEARCH) && pool_sts.cand_free;
		pool_ctl.step  = (state_q == ST_SEARCH) && !pool_sts.cand_free && !pool_sts.last;
	end

	lfsp_slot_pool #(
		.SLOTS(SLOTS)
	) u_pool (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (pool_ctl),
		.rel_idx (SW'(item.slot_sel)),
		.sts     (pool_sts),
		.cand    (cand)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			prev_cr_q      <= 1'b0;
			pend_q         <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
			st_wr_s1       <= 1'b0;
		end else begin
			st_wr_s1 <= (state_q == ST_COPY);
			if (emit_go) begin
				result_q       <= pend_q;
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (item.action)
							ACT_BYTE: begin
								if (is_cr || is_lf) begin
									prev_cr_q <= is_cr;
								end else begin
									prev_cr_q <= 1'b0;
									if (keep_byte) begin
										count_q <= count_q + 1'b1;
									end else begin
										ovf_q <= 1'b1;
									end
								end
								if (end_line) begin
									if (ovf_q) begin
										// An overflowed line reports an error and takes no slot.
										pend_q  <= '{kind: KIND_ERROR, default: '0};
										count_q <= '0;
										ovf_q   <= 1'b0;
										state_q <= ST_EMIT;
									end else if (count_q != '0) begin
										state_q <= ST_SEARCH;
									end
								end
							end
							ACT_REL: begin
								// The pool clears the busy bit itself.
							end
							ACT_READ: begin
								if (rd_ok) begin
									state_q <= ST_MEMRD;
								end else begin
									pend_q  <= '{kind: KIND_READ, default: '0};
									state_q <= ST_EMIT;
								end
							end
							ACT_DISC: begin
								count_q   <= '0;
								ovf_q     <= 1'b0;
								prev_cr_q <= 1'b0;
							end
						endcase
					end
				end
				ST_SEARCH: begin
					if (pool_sts.cand_free) begin
						pend_q  <= '{kind: KIND_LINE, slot: 3'(cand),
							line_length: 8'(count_q), read_data: 8'd0};
						state_q <= ST_COPY;
					end else if (pool_sts.last) begin
						// Every slot was probed and found busy.
						pend_q  <= '{kind: KIND_ERROR, default: '0};
						count_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_COPY: begin
					if (idx_q == count_q) begin
						count_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_MEMRD: begin
					state_q <= ST_MEMWAIT;
				end
				ST_MEMWAIT: begin
					pend_q  <= '{kind: KIND_READ, slot: 3'd0, line_length: 8'd0,
						read_data: ls_rdata_q};
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Copy pipeline: stage 1 registers the write address together with the byte read
	// from the assembly buffer; the final beat writes the terminating zero byte.
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_addr_q <= AW'(AW'(item.slot_sel) * AW'(LINE_BYTES)) + AW'(item.byte_offset);
		end
		if (pool_ctl.take) begin
			wr_addr_q <= AW'(AW'(cand) * AW'(LINE_BYTES));
			idx_q     <= '0;
		end else if (state_q == ST_COPY) begin
			wr_addr_q <= wr_addr_q + 1'b1;
			if (idx_q != count_q) begin
				idx_q <= idx_q + 1'b1;
			end
		end
		addr_s1 <= wr_addr_q;
		zero_s1 <= (idx_q == count_q);
	end

	always_ff @(posedge clk) begin
		if (keep_byte) begin
			abuf_mem[count_q] <= item.rx_byte;
		end
		abuf_rdata_q <= abuf_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (st_wr_s1) begin
			ls_mem[addr_s1] <= zero_s1 ? 8'd0 : abuf_rdata_q;
		end
		ls_rdata_q <= ls_mem[rd_addr_q];
	end

endmodule

// ===== rtl/core/lfsp_checker.sv =====
// Port-level checker of the line framer slot pool and its bind statement.
`include "line_framer_slot_pool_assert.svh"

module lfsp_port_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input lfsp_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input lfsp_pkg::result_t result
);
	import lfsp_pkg::*;

	logic item_acc;
	logic plain_byte;
	logic res_hold;
	logic res_other;
	logic res_clean;

	assign item_acc   = item_valid && !item_stall;
	assign plain_byte = (item.action == ACT_BYTE) && (item.rx_byte != CHAR_CR) &&
		(item.rx_byte != CHAR_LF);
	assign res_hold   = result_valid && result_stall;
	assign res_other  = result_valid && (result.kind != KIND_LINE);
	assign res_clean  = (result.slot == 3'd0) && (result.line_length == 8'd0);

	// A stalled result stays offered.
	`LFSP_ASSERT_NXT(a_result_held, res_hold, result_valid && $stable(result), "stalled result changed")

	// Only a line result carries a slot and a length.
	`LFSP_ASSERT_IMP(a_non_line_zero, res_other, res_clean, "non-line result carries slot or length")

	// An ordinary data byte leaves the sequencer idle, so the input is free again in the next cycle.
	`LFSP_ASSERT_NXT(a_byte_one_cycle, item_acc && plain_byte, !item_stall, "data byte held the input")

	// A read always occupies the sequencer for at least its next cycle.
	`LFSP_ASSERT_NXT(a_read_busy, item_acc && (item.action == ACT_READ), item_stall, "read not held")

endmodule

bind line_framer_slot_pool lfsp_port_checker u_lfsp_checker (.*);

// ===== sim/lfsp_checker.sv =====
// Result checker of the line framer slot pool: predicts each transaction's result and compares.
`timescale 1ns / 100ps
module lfsp_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	input  logic                               item_stall,
	input  lfsp_pkg::item_t                    item,
	input  logic                               result_valid,
	input  logic                               result_stall,
	input  lfsp_pkg::result_t                  result,
	output int                                 mismatches,
	output int                                 outstanding,
	output logic [lfsp_pkg::SLOTS_DEF-1:0]      stored_any,
	output logic [lfsp_pkg::SLOTS_DEF-1:0][7:0] stored_top
);
	import lfsp_pkg::*;

	logic [7:0] frag_buf [LINE_BYTES_DEF];
	logic [7:0] frag_len;
	bit frag_ovf;
	bit after_cr;
	logic [7:0] pool_mem [SLOTS_DEF][LINE_BYTES_DEF];
	bit [SLOTS_DEF-1:0] pool_busy;
	int hunt_ptr;
	result_t due_q [$];
	result_t fresh;
	result_t want;
	bit made;

	// Ends the line under assembly and files it into the pool, or predicts an error when it overflowed or no slot is free.
	task close_line(output bit got, output result_t r);
		int k;
		int pick;
		bit hit;
		got = 1'b0;
		r = '0;
		hit = 1'b0;
		pick = 0;
		if (frag_ovf) begin
			got = 1'b1;
			r.kind = KIND_ERROR;
		end else if (frag_len > 0) begin
			for (k = 0; k < SLOTS_DEF; k++) begin
				if (!hit && !pool_busy[(hunt_ptr + k) % SLOTS_DEF]) begin
					hit = 1'b1;
					pick = (hunt_ptr + k) % SLOTS_DEF;
				end
			end
			got = 1'b1;
			if (hit) begin
				pool_busy[pick] = 1'b1;
				hunt_ptr = (pick + 1) % SLOTS_DEF;
				for (k = 0; k < frag_len; k++)
					pool_mem[pick][k] = frag_buf[k];
				pool_mem[pick][frag_len] = 8'h00;
				stored_any[pick] = 1'b1;
				if (frag_len > stored_top[pick])
					stored_top[pick] = frag_len;
				r.kind = KIND_LINE;
				r.slot = pick[2:0];
				r.line_length = frag_len;
			end else begin
				r.kind = KIND_ERROR;
			end
		end
		frag_len = '0;
		frag_ovf = 1'b0;
	endtask

	task framer_step(input item_t it, output bit got, output result_t r);
		got = 1'b0;
		r = '0;
		case (it.action)
			ACT_BYTE: begin
				if (it.rx_byte == CHAR_CR) begin
					after_cr = 1'b1;
					close_line(got, r);
				end else if (it.rx_byte == CHAR_LF) begin
					if (after_cr)
						after_cr = 1'b0;
					else
						close_line(got, r);
				end else begin
					after_cr = 1'b0;
					if (frag_len < LINE_BYTES_DEF - 1) begin
						frag_buf[frag_len] = it.rx_byte;
						frag_len++;
					end else begin
						frag_ovf = 1'b1;
					end
				end
			end
			ACT_REL: begin
				if (it.slot_sel < SLOTS_DEF)
					pool_busy[it.slot_sel] = 1'b0;
			end
			ACT_READ: begin
				got = 1'b1;
				r.kind = KIND_READ;
				if (it.slot_sel < SLOTS_DEF && it.byte_offset < LINE_BYTES_DEF)
					r.read_data = pool_mem[it.slot_sel][it.byte_offset];
			end
			default: begin
				frag_len = '0;
				frag_ovf = 1'b0;
				after_cr = 1'b0;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_len = '0;
			frag_ovf = 1'b0;
			after_cr = 1'b0;
			pool_busy = '0;
			hunt_ptr = 0;
			due_q.delete();
			mismatches = 0;
			outstanding = 0;
			stored_any = '0;
			stored_top = '0;
		end else begin
			// The prediction goes in first, so a same-cycle result still finds it.
			if (item_valid && !item_stall) begin
				framer_step(item, made, fresh);
				if (made)
					due_q.push_back(fresh);
			end
			if (result_valid && !result_stall) begin
				if (due_q.size() == 0) begin
					$error("unexpected result transaction: kind %0d slot %0d length %0d data %0d",
						result.kind, result.slot, result.line_length, result.read_data);
					mismatches++;
				end else begin
					want = due_q.pop_front();
					if (result.kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, result.kind);
						mismatches++;
					end
					if (result.slot !== want.slot) begin
						$error("slot: expected %0d, actual %0d", want.slot, result.slot);
						mismatches++;
					end
					if (result.line_length !== want.line_length) begin
						$error("line_length: expected %0d, actual %0d",
							want.line_length, result.line_length);
						mismatches++;
					end
					if (result.read_data !== want.read_data) begin
						$error("read_data: expected %0d, actual %0d",
							want.read_data, result.read_data);
						mismatches++;
					end
				end
			end
			outstanding = due_q.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top of the line framer slot pool: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_top;
	import lfsp_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int ITEM_TARGET = 1450;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	int mismatches;
	int outstanding;
	logic [SLOTS_DEF-1:0] stored_any;
	logic [SLOTS_DEF-1:0][7:0] stored_top;

	// Accepted item transactions so far.
	int sent = 0;
	// While calm is set neither side idles, giving one long back-to-back stretch.
	bit calm = 1'b0;
	// While drought is set no slot is released, so the pool runs full and
	// line ends turn into no-free-slot errors.
	bit drought = 1'b0;
	bit paused = 1'b0;
	int pick;

	line_framer_slot_pool dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	lfsp_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.stored_any  (stored_any),
		.stored_top  (stored_top)
	);

	always #HALF_PERIOD clk = ~clk;

	// The result side stalls about a third of the cycles, except in the calm stretch.
	// It changes only on the falling edge, so the rising edge always sees a settled value.
	always @(negedge clk) begin
		result_stall <= !calm && ($urandom_range(0, 99) < 33);
	end

	// Fields that the action does not use are still randomized, so every bit
	// of every field toggles during the run.
	function automatic item_t scramble(input logic [1:0] act);
		item_t it;
		it.action = act;
		it.rx_byte = 8'($urandom_range(0, 255));
		it.slot_sel = 3'($urandom_range(0, 7));
		it.byte_offset = 8'($urandom_range(0, 255));
		return it;
	endfunction

	// Line content: any byte except the two terminators.
	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CHAR_CR || b == CHAR_LF)
			b = b ^ 8'h40;
		return b;
	endfunction

	// Mostly short lines; now and then a medium one, an empty one, one of the
	// longest length that is kept, or one that overflows.
	function automatic int line_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70)
			return $urandom_range(1, 12);
		if (p < 88)
			return $urandom_range(13, 60);
		if (p < 93)
			return 0;
		if (p < 96)
			return LINE_BYTES_DEF - 1;
		return $urandom_range(LINE_BYTES_DEF, LINE_BYTES_DEF + 12);
	endfunction

	// Offers one item transaction. Entered right after a falling edge and left
	// right after a falling edge, so valid and payload only change there. The
	// idle gap comes first, so gaps fall ahead of any phase of the block's work.
	task automatic push_item(input item_t x);
		while (!calm && $urandom_range(0, 99) < 33) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		item_t it;
		it = scramble(ACT_BYTE);
		it.rx_byte = b;
		push_item(it);
	endtask

	task automatic send_rel(input int sel);
		item_t it;
		it = scramble(ACT_REL);
		it.slot_sel = sel[2:0];
		push_item(it);
	endtask

	task automatic send_read(input int sel, input int off);
		item_t it;
		it = scramble(ACT_READ);
		it.slot_sel = sel[2:0];
		it.byte_offset = off[7:0];
		push_item(it);
	endtask

	task automatic send_disc();
		push_item(scramble(ACT_DISC));
	endtask

	// A line of n content bytes, sometimes cut by a disconnect, ended by a
	// terminator pattern: CR, LF, CR LF, or LF LF (the second LF ends an empty line).
	task automatic send_line(input int n);
		int cut;
		int k;
		cut = ($urandom_range(0, 99) < 6) ? $urandom_range(0, n) : -1;
		for (k = 0; k < n; k++) begin
			if (k == cut)
				send_disc();
			send_byte(text_byte());
		end
		case ($urandom_range(0, 3))
			0: send_byte(CHAR_CR);
			1: send_byte(CHAR_LF);
			2: begin
				send_byte(CHAR_CR);
				send_byte(CHAR_LF);
			end
			default: begin
				send_byte(CHAR_LF);
				send_byte(CHAR_LF);
			end
		endcase
	endtask

	// Reads only bytes that some stored line has written (the terminator
	// included); a share of the reads goes past the end of the slot instead.
	// The written range only grows, so a view that lags by a few transactions
	// is still safe.
	task automatic read_somewhere();
		int s;
		int k;
		s = $urandom_range(0, SLOTS_DEF - 1);
		for (k = 0; k < SLOTS_DEF && !stored_any[s]; k++)
			s = (s + 1) % SLOTS_DEF;
		if (!stored_any[s] || $urandom_range(0, 99) < 15)
			send_read($urandom_range(0, SLOTS_DEF - 1), $urandom_range(LINE_BYTES_DEF, 255));
		else
			send_read(s, $urandom_range(0, stored_top[s]));
	endtask

	// Holds the item side idle until every predicted result transaction has arrived.
	task automatic drain();
		item_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening. A read past the end of a slot answers zero, and a
		// release of a free slot does nothing.
		send_read(0, 255);
		send_read(5, LINE_BYTES_DEF);
		send_rel(3);
		// A lone LF closes an empty line: no result.
		send_byte(CHAR_LF);
		// The extreme byte values form a line; it lands in slot 0.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CHAR_CR);
		// The LF right after that CR is swallowed.
		send_byte(CHAR_LF);
		// CR CR: the second CR ends an empty line.
		send_byte(CHAR_CR);
		send_byte(CHAR_CR);
		// Read back both bytes and the zero terminator of slot 0.
		send_read(0, 0);
		send_read(0, 1);
		send_read(0, 2);
		// A disconnect throws away a partial line, so the LF finds nothing.
		send_byte(8'h78);
		send_disc();
		send_byte(CHAR_LF);
		// A line ended by a bare LF goes to slot 1.
		send_byte(8'h41);
		send_byte(CHAR_LF);
		// Slot 0 is freed, but the search starts after slot 1 and picks slot 2.
		send_rel(0);
		send_byte(8'h42);
		send_byte(CHAR_CR);
		send_read(7, 200);
		send_read(2, 1);
		drain();

		// The longest line that fits and one that overflows come first.
		send_line(LINE_BYTES_DEF - 1);
		send_line(LINE_BYTES_DEF + 3);

		while (sent < ITEM_TARGET) begin
			drought = (sent >= 450 && sent < 750);
			calm = (sent >= 900 && sent < 1100);
			if (!paused && sent >= 700) begin
				paused = 1'b1;
				drain();
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_line(line_len());
			end else if (pick < 70) begin
				if (drought)
					send_line(line_len());
				else
					send_rel($urandom_range(0, SLOTS_DEF - 1));
			end else if (pick < 88) begin
				read_somewhere();
			end else if (pick < 92) begin
				send_disc();
			end else if (pick < 96) begin
				// Stray terminators outside any line pattern.
				send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end
		calm = 1'b0;

		// Wait for the last results, then leave time for any unexpected extra result to
		// show up before judging.
		drain();
		repeat (400) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// A correct run stays far below this; reaching it means the block hung.
	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lfsp_pkg.sv
rtl/core/lfsp_slot_pool.sv
rtl/core/line_framer_slot_pool.sv
rtl/core/lfsp_checker.sv
sim/lfsp_checker.sv
sim/tb_top.sv
